// File: sv/rws_pkg.sv
// Shared types and constants for the RIFF/WAVE stream parser.
`timescale 1ns / 1ps

package rws_pkg;

    localparam logic [31:0] TAG_RIFF      = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE      = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT       = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA      = 32'h6461_7461;
    localparam logic [31:0] SIZE_RESERVED = 32'hFFFF_FFFF;
    localparam logic [31:0] FMT_MIN_LEN   = 32'd16;
    localparam logic [15:0] FMT_PCM       = 16'd1;

    // Byte positions inside a tag, a size field and the fmt body
    localparam logic [3:0] FIELD_LAST_BYTE = 4'd3;
    localparam logic [3:0] FMT_LAST_BYTE   = 4'd15;

    localparam logic [1:0] KIND_PCM    = 2'd0;
    localparam logic [1:0] KIND_FORMAT = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;
    localparam logic [1:0] KIND_REJECT = 2'd3;

    localparam logic [2:0] ST_RIFF_TAG    = 3'd0;
    localparam logic [2:0] ST_WAVE_TAG    = 3'd1;
    localparam logic [2:0] ST_RESERVED    = 3'd2;
    localparam logic [2:0] ST_NON_PCM     = 3'd3;
    localparam logic [2:0] ST_SHORT_FMT   = 3'd4;
    localparam logic [2:0] ST_DATA_FIRST  = 3'd5;
    localparam logic [2:0] ST_EARLY_END   = 3'd6;
    localparam logic [2:0] ST_NONE        = 3'd0;

    typedef enum logic [10:0] {
        PH_RIFF_TAG   = 11'b000_0000_0001,
        PH_RIFF_SIZE  = 11'b000_0000_0010,
        PH_WAVE_TAG   = 11'b000_0000_0100,
        PH_CHUNK_TAG  = 11'b000_0000_1000,
        PH_CHUNK_SIZE = 11'b000_0001_0000,
        PH_FMT_BODY   = 11'b000_0010_0000,
        PH_SKIP       = 11'b000_0100_0000,
        PH_PAD        = 11'b000_1000_0000,
        PH_DATA       = 11'b001_0000_0000,
        PH_DONE       = 11'b010_0000_0000,
        PH_REJECTED   = 11'b100_0000_0000
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  pcm_byte;
        logic        data_last;
        logic [15:0] channels;
        logic [31:0] frame_rate;
        logic [15:0] sample_size;
        logic [2:0]  status;
    } res_t;

endpackage

// File: sv/rws_if.sv
// Valid/ready channel interfaces for the byte stream and the result stream.
`timescale 1ns / 1ps

interface rws_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_stream;

    modport source (output valid, input ready, output in_byte, output end_of_stream);
    modport sink (input valid, output ready, input in_byte, input end_of_stream);
endinterface

interface rws_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  pcm_byte;
    logic        data_last;
    logic [15:0] channels;
    logic [31:0] frame_rate;
    logic [15:0] sample_size;
    logic [2:0]  status;

    modport source (
        output valid, input ready, output kind, output pcm_byte, output data_last,
        output channels, output frame_rate, output sample_size, output status
    );
    modport sink (
        input valid, output ready, input kind, input pcm_byte, input data_last,
        input channels, input frame_rate, input sample_size, input status
    );
endinterface

// File: sv/rws_parse.sv
// Header walker: parse state registers and the per-byte result logic.
`timescale 1ns / 1ps

module rws_parse
    import rws_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       end_of_stream,
    output logic       res_valid,
    output res_t       res
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  byte_count_reg, byte_count_next;
    logic [31:0] tag_shift_reg, tag_shift_next;
    logic [31:0] chunk_length_reg, chunk_length_next;
    logic        pad_pending_reg, pad_pending_next;
    logic        format_seen_reg, format_seen_next;
    logic [15:0] format_code_reg, format_code_next;
    logic [15:0] channel_count_reg, channel_count_next;
    logic [31:0] rate_value_reg, rate_value_next;
    logic [15:0] sample_width_reg, sample_width_next;

    logic [3:0]  byte_inc;
    logic [31:0] size_word;
    logic [31:0] fmt_rest;
    logic        do_reject;
    logic [2:0]  reject_cause;

    assign byte_inc  = byte_count_reg + 4'd1;
    assign size_word = {in_byte, chunk_length_reg[31:8]};
    assign fmt_rest  = chunk_length_reg - FMT_MIN_LEN;

    always_comb
    begin
        phase_next         = phase_reg;
        byte_count_next    = byte_count_reg;
        tag_shift_next     = tag_shift_reg;
        chunk_length_next  = chunk_length_reg;
        pad_pending_next   = pad_pending_reg;
        format_seen_next   = format_seen_reg;
        format_code_next   = format_code_reg;
        channel_count_next = channel_count_reg;
        rate_value_next    = rate_value_reg;
        sample_width_next  = sample_width_reg;
        res_valid          = 1'b0;
        res                = '0;
        do_reject          = 1'b0;
        reject_cause       = ST_NONE;

        unique case (phase_reg)
            PH_RIFF_TAG, PH_WAVE_TAG, PH_CHUNK_TAG:
            begin
                tag_shift_next = {tag_shift_reg[23:0], in_byte};
                byte_count_next = byte_inc;
                if (byte_count_reg == FIELD_LAST_BYTE)
                begin
                    byte_count_next = '0;
                    if (phase_reg == PH_RIFF_TAG)
                    begin
                        if (tag_shift_next != TAG_RIFF)
                        begin
                            do_reject    = 1'b1;
                            reject_cause = ST_RIFF_TAG;
                        end
                        else
                        begin
                            phase_next = PH_RIFF_SIZE;
                        end
                    end
                    else if (phase_reg == PH_WAVE_TAG)
                    begin
                        if (tag_shift_next != TAG_WAVE)
                        begin
                            do_reject    = 1'b1;
                            reject_cause = ST_WAVE_TAG;
                        end
                        else
                        begin
                            phase_next = PH_CHUNK_TAG;
                        end
                    end
                    else
                    begin
                        phase_next = PH_CHUNK_SIZE;
                    end
                end
            end
            PH_RIFF_SIZE, PH_CHUNK_SIZE:
            begin
                chunk_length_next = size_word;
                byte_count_next = byte_inc;
                if (byte_count_reg == FIELD_LAST_BYTE)
                begin
                    byte_count_next = '0;
                    if (phase_reg == PH_RIFF_SIZE)
                    begin
                        phase_next = PH_WAVE_TAG;
                    end
                    else
                    begin
                        pad_pending_next = size_word[0];
                        if (size_word == SIZE_RESERVED)
                        begin
                            do_reject    = 1'b1;
                            reject_cause = ST_RESERVED;
                        end
                        else if (tag_shift_reg == TAG_DATA)
                        begin
                            if (!format_seen_reg)
                            begin
                                do_reject    = 1'b1;
                                reject_cause = ST_DATA_FIRST;
                            end
                            else if (size_word == '0)
                            begin
                                res_valid  = 1'b1;
                                res.kind   = KIND_EMPTY;
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                phase_next = PH_DATA;
                            end
                        end
                        else if (tag_shift_reg == TAG_FMT)
                        begin
                            if (size_word < FMT_MIN_LEN)
                            begin
                                do_reject    = 1'b1;
                                reject_cause = ST_SHORT_FMT;
                            end
                            else
                            begin
                                format_code_next   = '0;
                                channel_count_next = '0;
                                rate_value_next    = '0;
                                sample_width_next  = '0;
                                phase_next         = PH_FMT_BODY;
                            end
                        end
                        else if (size_word == '0)
                        begin
                            // an empty chunk has an even size, so no pad byte
                            phase_next = PH_CHUNK_TAG;
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                end
            end
            PH_FMT_BODY:
            begin
                case (byte_count_reg)
                    4'd0:  format_code_next[7:0]    = in_byte;
                    4'd1:  format_code_next[15:8]   = in_byte;
                    4'd2:  channel_count_next[7:0]  = in_byte;
                    4'd3:  channel_count_next[15:8] = in_byte;
                    4'd4:  rate_value_next[7:0]     = in_byte;
                    4'd5:  rate_value_next[15:8]    = in_byte;
                    4'd6:  rate_value_next[23:16]   = in_byte;
                    4'd7:  rate_value_next[31:24]   = in_byte;
                    4'd14: sample_width_next[7:0]   = in_byte;
                    4'd15: sample_width_next[15:8]  = in_byte;
                    default: ;
                endcase
                byte_count_next = byte_inc;
                if (byte_count_reg == FMT_LAST_BYTE)
                begin
                    byte_count_next = '0;
                    if (format_code_next != FMT_PCM)
                    begin
                        do_reject    = 1'b1;
                        reject_cause = ST_NON_PCM;
                    end
                    else
                    begin
                        format_seen_next    = 1'b1;
                        res_valid           = 1'b1;
                        res.kind            = KIND_FORMAT;
                        res.channels        = channel_count_next;
                        res.frame_rate      = rate_value_next;
                        res.sample_size     = sample_width_next;
                        chunk_length_next   = fmt_rest;
                        if (fmt_rest == '0)
                        begin
                            phase_next = pad_pending_reg ? PH_PAD : PH_CHUNK_TAG;
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                end
            end
            PH_SKIP:
            begin
                chunk_length_next = chunk_length_reg - 32'd1;
                if (chunk_length_reg == 32'd1)
                begin
                    byte_count_next = '0;
                    phase_next = pad_pending_reg ? PH_PAD : PH_CHUNK_TAG;
                end
            end
            PH_PAD:
            begin
                pad_pending_next = 1'b0;
                phase_next       = PH_CHUNK_TAG;
            end
            PH_DATA:
            begin
                chunk_length_next = chunk_length_reg - 32'd1;
                res_valid         = 1'b1;
                res.kind          = KIND_PCM;
                res.pcm_byte      = in_byte;
                if (chunk_length_reg == 32'd1)
                begin
                    res.data_last = 1'b1;
                    phase_next    = PH_DONE;
                end
            end
            default: ;
        endcase

        if (do_reject)
        begin
            phase_next = PH_REJECTED;
        end

        // early end overrides whatever this byte produced
        if (end_of_stream && phase_next != PH_DONE && phase_next != PH_REJECTED)
        begin
            do_reject    = 1'b1;
            reject_cause = ST_EARLY_END;
        end

        if (do_reject)
        begin
            res_valid  = 1'b1;
            res        = '0;
            res.kind   = KIND_REJECT;
            res.status = reject_cause;
        end

        // every file ends with a full return to the start
        if (end_of_stream)
        begin
            phase_next         = PH_RIFF_TAG;
            byte_count_next    = '0;
            tag_shift_next     = '0;
            chunk_length_next  = '0;
            pad_pending_next   = 1'b0;
            format_seen_next   = 1'b0;
            format_code_next   = '0;
            channel_count_next = '0;
            rate_value_next    = '0;
            sample_width_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_RIFF_TAG;
            byte_count_reg    <= '0;
            tag_shift_reg     <= '0;
            chunk_length_reg  <= '0;
            pad_pending_reg   <= 1'b0;
            format_seen_reg   <= 1'b0;
            format_code_reg   <= '0;
            channel_count_reg <= '0;
            rate_value_reg    <= '0;
            sample_width_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg         <= phase_next;
            byte_count_reg    <= byte_count_next;
            tag_shift_reg     <= tag_shift_next;
            chunk_length_reg  <= chunk_length_next;
            pad_pending_reg   <= pad_pending_next;
            format_seen_reg   <= format_seen_next;
            format_code_reg   <= format_code_next;
            channel_count_reg <= channel_count_next;
            rate_value_reg    <= rate_value_next;
            sample_width_reg  <= sample_width_next;
        end
    end

endmodule

// File: sv/rws_out_stage.sv
// Result register that drives the result channel and paces the byte input.
`timescale 1ns / 1ps

module rws_out_stage
    import rws_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  res_t       res,
    output logic       room,
    rws_out_if.source  result
);

    logic valid_reg;
    res_t res_reg;

    // a new request may enter when the register is empty or being drained
    assign room = !valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (room)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (room && load)
        begin
            res_reg <= res;
        end
    end

    assign result.valid       = valid_reg;
    assign result.kind        = res_reg.kind;
    assign result.pcm_byte    = res_reg.pcm_byte;
    assign result.data_last   = res_reg.data_last;
    assign result.channels    = res_reg.channels;
    assign result.frame_rate  = res_reg.frame_rate;
    assign result.sample_size = res_reg.sample_size;
    assign result.status      = res_reg.status;

endmodule

// File: sv/riff_wave_stream_parser.sv
// RIFF/WAVE stream parser top level: one file byte per request.
// Results are registered: a result shows on the result channel in the cycle after its byte is taken.
// Throughput: one byte per cycle; the single result register sets the pace, so the
// byte input stalls only while a finished result waits on the result channel.
// Reset: rst_n clears the parse state to the start of a file and empties the result
// register; a byte marked end_of_stream returns the parser to that same state.
`timescale 1ns / 1ps

module riff_wave_stream_parser
    import rws_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rws_in_if.sink    byte_stream,
    rws_out_if.source result
);

    logic room;
    logic accept;
    logic res_valid;
    res_t res;

    assign byte_stream.ready = room;
    assign accept = byte_stream.valid && room;

    rws_parse u_parse (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .in_byte       (byte_stream.in_byte),
        .end_of_stream (byte_stream.end_of_stream),
        .res_valid     (res_valid),
        .res           (res)
    );

    rws_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept && res_valid),
        .res    (res),
        .room   (room),
        .result (result)
    );

    a_ready_when_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        !result.valid |-> byte_stream.ready
    ) else $error("byte input stalled with an empty result register");

    a_last_only_on_pcm: assert property (
        @(posedge clk) disable iff (!rst_n)
        result.valid && result.data_last |-> result.kind == KIND_PCM
    ) else $error("data_last set on a result that is not a data byte");

    a_status_only_on_reject: assert property (
        @(posedge clk) disable iff (!rst_n)
        result.valid && result.kind != KIND_REJECT |-> result.status == ST_NONE
    ) else $error("status set on a result that is not a reject");

    a_drain_then_take: assert property (
        @(posedge clk) disable iff (!rst_n)
        result.valid && result.ready && !byte_stream.valid |=> !result.valid
    ) else $error("result register refilled without an accepted byte");

endmodule

// File: tb/sv/riff_wave_stream_parser_test.sv
// Self-checking testbench for the RIFF/WAVE stream parser: directed table, random files.
`timescale 1ns / 1ps

module riff_wave_stream_parser_test;
    import rws_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } wav_byte_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       pinned;
        logic       has_result;
        res_t       want;
    } dir_row_t;

    typedef enum int {
        FLAW_NONE,
        FLAW_RIFF,
        FLAW_WAVE,
        FLAW_RESERVED,
        FLAW_EARLY_DATA,
        FLAW_SHORT_FMT,
        FLAW_NON_PCM
    } flaw_t;

    localparam res_t NO_RESULT   = '0;
    localparam res_t BAD_RIFF    = {KIND_REJECT, 73'd0, ST_RIFF_TAG};
    localparam res_t BAD_WAVE    = {KIND_REJECT, 73'd0, ST_WAVE_TAG};
    localparam res_t CUT_SHORT   = {KIND_REJECT, 73'd0, ST_EARLY_END};
    localparam int   RANDOM_BYTES = 650;
    localparam int   SEGMENT_LEN  = 90;
    localparam int   HOLD_CYCLES  = 64;

    // Unpinned rows are checked against the parse predictor
    localparam dir_row_t DIRECTED_ROWS [24] = '{
        '{8'h52, 1'b0, 1'b1, 1'b0, NO_RESULT},
        '{8'h49, 1'b0, 1'b1, 1'b0, NO_RESULT},
        '{8'h46, 1'b0, 1'b1, 1'b0, NO_RESULT},
        '{8'h58, 1'b0, 1'b1, 1'b1, BAD_RIFF},
        '{8'h00, 1'b1, 1'b1, 1'b0, NO_RESULT},
        '{8'hFF, 1'b1, 1'b1, 1'b1, CUT_SHORT},
        '{8'h52, 1'b0, 1'b1, 1'b0, NO_RESULT},
        '{8'h49, 1'b0, 1'b1, 1'b0, NO_RESULT},
        '{8'h46, 1'b0, 1'b1, 1'b0, NO_RESULT},
        '{8'h46, 1'b0, 1'b1, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'h57, 1'b0, 1'b1, 1'b0, NO_RESULT},
        '{8'h41, 1'b0, 1'b1, 1'b0, NO_RESULT},
        '{8'h56, 1'b0, 1'b1, 1'b0, NO_RESULT},
        '{8'h58, 1'b0, 1'b1, 1'b1, BAD_WAVE},
        '{8'hFF, 1'b1, 1'b1, 1'b0, NO_RESULT},
        '{8'h52, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'h49, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'h46, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'h46, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, 1'b1, 1'b1, CUT_SHORT}
    };

    logic clk = 1'b0;
    logic rst_n;

    rws_in_if  bs ();
    rws_out_if rs ();

    riff_wave_stream_parser dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (bs),
        .result      (rs)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Parse predictor state
    phase_t      parse_phase;
    logic [31:0] field_count;
    logic [31:0] tag_word;
    logic [31:0] chunk_len;
    logic        pad_due;
    logic        fmt_known;
    logic [15:0] wave_format;
    logic [15:0] chan_count;
    logic [31:0] rate_hz;
    logic [15:0] sample_bits;

    res_t      expected_results [$];
    wav_byte_t byte_plan [$];
    logic [7:0] file_bytes [$];

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int stall_pct      = 0;
    logic hold_wanted  = 1'b0;

    function automatic void reset_parser();
        parse_phase = PH_RIFF_TAG;
        field_count = '0;
        tag_word    = '0;
        chunk_len   = '0;
        pad_due     = 1'b0;
        fmt_known   = 1'b0;
        wave_format = '0;
        chan_count  = '0;
        rate_hz     = '0;
        sample_bits = '0;
    endfunction

    function automatic res_t reject_with(input logic [2:0] why);
        res_t r;
        r = '0;
        r.kind = KIND_REJECT;
        r.status = why;
        parse_phase = PH_REJECTED;
        return r;
    endfunction

    function automatic void close_body();
        field_count = '0;
        parse_phase = pad_due ? PH_PAD : PH_CHUNK_TAG;
    endfunction

    function automatic void skip_body(input logic [31:0] len);
        chunk_len = len;
        if (len == 0)
            close_body();
        else
            parse_phase = PH_SKIP;
    endfunction

    task automatic predict_byte(input logic [7:0] b, input logic eos,
                                output logic produced, output res_t res);
        produced = 1'b0;
        res = '0;
        case (parse_phase)
            PH_RIFF_TAG, PH_WAVE_TAG, PH_CHUNK_TAG:
            begin
                tag_word = {tag_word[23:0], b};
                field_count++;
                if (field_count >= 4)
                begin
                    field_count = '0;
                    if (parse_phase == PH_RIFF_TAG)
                    begin
                        if (tag_word != TAG_RIFF)
                        begin
                            res = reject_with(ST_RIFF_TAG);
                            produced = 1'b1;
                        end
                        else
                            parse_phase = PH_RIFF_SIZE;
                    end
                    else if (parse_phase == PH_WAVE_TAG)
                    begin
                        if (tag_word != TAG_WAVE)
                        begin
                            res = reject_with(ST_WAVE_TAG);
                            produced = 1'b1;
                        end
                        else
                            parse_phase = PH_CHUNK_TAG;
                    end
                    else
                        parse_phase = PH_CHUNK_SIZE;
                end
            end
            PH_RIFF_SIZE, PH_CHUNK_SIZE:
            begin
                chunk_len = {b, chunk_len[31:8]};
                field_count++;
                if (field_count >= 4)
                begin
                    field_count = '0;
                    if (parse_phase == PH_RIFF_SIZE)
                        parse_phase = PH_WAVE_TAG;
                    else
                    begin
                        pad_due = chunk_len[0];
                        if (chunk_len == SIZE_RESERVED)
                        begin
                            res = reject_with(ST_RESERVED);
                            produced = 1'b1;
                        end
                        else if (tag_word == TAG_DATA)
                        begin
                            if (!fmt_known)
                            begin
                                res = reject_with(ST_DATA_FIRST);
                                produced = 1'b1;
                            end
                            else if (chunk_len == 0)
                            begin
                                res.kind = KIND_EMPTY;
                                produced = 1'b1;
                                parse_phase = PH_DONE;
                            end
                            else
                                parse_phase = PH_DATA;
                        end
                        else if (tag_word == TAG_FMT)
                        begin
                            if (chunk_len < FMT_MIN_LEN)
                            begin
                                res = reject_with(ST_SHORT_FMT);
                                produced = 1'b1;
                            end
                            else
                            begin
                                wave_format = '0;
                                chan_count  = '0;
                                rate_hz     = '0;
                                sample_bits = '0;
                                parse_phase = PH_FMT_BODY;
                            end
                        end
                        else
                            skip_body(chunk_len);
                    end
                end
            end
            PH_FMT_BODY:
            begin
                if (field_count < 2)
                    wave_format[8*field_count[0] +: 8] = b;
                else if (field_count < 4)
                    chan_count[8*field_count[0] +: 8] = b;
                else if (field_count < 8)
                    rate_hz[8*field_count[1:0] +: 8] = b;
                else if (field_count >= 14 && field_count < 16)
                    sample_bits[8*field_count[0] +: 8] = b;
                field_count++;
                if (field_count >= FMT_MIN_LEN)
                begin
                    field_count = '0;
                    if (wave_format != FMT_PCM)
                        res = reject_with(ST_NON_PCM);
                    else
                    begin
                        fmt_known = 1'b1;
                        res.kind = KIND_FORMAT;
                        res.channels = chan_count;
                        res.frame_rate = rate_hz;
                        res.sample_size = sample_bits;
                        skip_body(chunk_len - FMT_MIN_LEN);
                    end
                    produced = 1'b1;
                end
            end
            PH_SKIP:
            begin
                chunk_len--;
                if (chunk_len == 0)
                    close_body();
            end
            PH_PAD:
            begin
                pad_due = 1'b0;
                parse_phase = PH_CHUNK_TAG;
            end
            PH_DATA:
            begin
                chunk_len--;
                res.kind = KIND_PCM;
                res.pcm_byte = b;
                produced = 1'b1;
                if (chunk_len == 0)
                begin
                    res.data_last = 1'b1;
                    parse_phase = PH_DONE;
                end
            end
            default:
            begin
            end
        endcase

        // An unfinished file cut by end of stream overrides whatever this byte gave
        if (eos)
        begin
            if (parse_phase != PH_DONE && parse_phase != PH_REJECTED)
            begin
                res = reject_with(ST_EARLY_END);
                produced = 1'b1;
            end
            reset_parser();
        end
    endtask

    function automatic logic [31:0] wild32();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_le16(input logic [15:0] h);
        file_bytes.push_back(h[7:0]);
        file_bytes.push_back(h[15:8]);
    endtask

    task automatic push_le32(input logic [31:0] w);
        for (int k = 0; k < 4; k++)
            file_bytes.push_back(w[8*k +: 8]);
    endtask

    task automatic push_tag(input logic [31:0] t);
        for (int k = 3; k >= 0; k--)
            file_bytes.push_back(t[8*k +: 8]);
    endtask

    task automatic push_noise(input int count);
        repeat (count)
            file_bytes.push_back(8'($urandom));
    endtask

    task automatic push_unknown_chunk();
        logic [31:0] len;
        // Now and then a huge chunk: the file ends while it is still being skipped
        if ($urandom_range(0, 7) == 0)
            len = 32'h0001_0000 + $urandom_range(0, 9);
        else
            len = $urandom_range(0, 5);
        push_tag($urandom);
        push_le32(len);
        push_noise(len > 6 ? 6 : len + len[0]);
    endtask

    task automatic push_format_chunk(input logic [15:0] code, input logic [31:0] len);
        push_tag(TAG_FMT);
        push_le32(len);
        if (len < FMT_MIN_LEN)
        begin
            push_noise($urandom_range(0, 2));
            return;
        end
        push_le16(code);
        push_le16(16'(wild32()));
        push_le32(wild32());
        push_noise(6);
        push_le16(16'(wild32()));
        push_noise(len - FMT_MIN_LEN + len[0]);
    endtask

    task automatic compose_file(input flaw_t flaw);
        logic [31:0] len;
        logic [15:0] code;
        logic        huge;
        if (flaw == FLAW_RIFF)
        begin
            push_tag(TAG_RIFF ^ (32'd1 << $urandom_range(0, 31)));
            push_noise($urandom_range(0, 2));
            return;
        end
        push_tag(TAG_RIFF);
        push_le32(wild32());
        if (flaw == FLAW_WAVE)
        begin
            push_tag(TAG_WAVE ^ (32'd1 << $urandom_range(0, 31)));
            push_noise($urandom_range(0, 2));
            return;
        end
        push_tag(TAG_WAVE);
        repeat ($urandom_range(0, 1))
            push_unknown_chunk();
        case (flaw)
            FLAW_RESERVED:
            begin
                case ($urandom_range(0, 2))
                    0: push_tag(TAG_FMT);
                    1: push_tag(TAG_DATA);
                    default: push_tag($urandom);
                endcase
                push_le32(SIZE_RESERVED);
                push_noise($urandom_range(0, 2));
                return;
            end
            FLAW_EARLY_DATA:
            begin
                push_tag(TAG_DATA);
                push_le32($urandom_range(0, 4));
                push_noise($urandom_range(0, 2));
                return;
            end
            FLAW_SHORT_FMT:
            begin
                push_format_chunk(FMT_PCM, $urandom_range(0, 15));
                return;
            end
            FLAW_NON_PCM:
            begin
                code = 16'(wild32());
                if (code == FMT_PCM)
                    code = '0;
                push_format_chunk(code, FMT_MIN_LEN + $urandom_range(0, 3));
                push_noise($urandom_range(0, 2));
                return;
            end
            default:
            begin
            end
        endcase
        push_format_chunk(FMT_PCM, FMT_MIN_LEN + $urandom_range(0, 3));
        case ($urandom_range(0, 3))
            0: push_unknown_chunk();
            1: push_format_chunk(FMT_PCM, FMT_MIN_LEN);
            default:
            begin
            end
        endcase
        push_tag(TAG_DATA);
        huge = 1'b0;
        case ($urandom_range(0, 9))
            0: len = '0;
            1:
            begin
                len = 32'h0000_1000 | 32'($urandom_range(0, 32'h0FFF_FFFF));
                huge = 1'b1;
            end
            default: len = $urandom_range(1, 8);
        endcase
        push_le32(len);
        push_noise(huge ? $urandom_range(1, 6) : len);
    endtask

    task automatic add_file();
        int    pick;
        int    keep;
        flaw_t flaw;
        file_bytes.delete();
        pick = $urandom_range(0, 99);
        if (pick < 12)
            push_noise($urandom_range(1, 10));
        else
        begin
            flaw = (pick < 58) ? FLAW_NONE : flaw_t'($urandom_range(FLAW_RIFF, FLAW_NON_PCM));
            compose_file(flaw);
            if ($urandom_range(0, 99) < 15)
            begin
                keep = $urandom_range(1, file_bytes.size());
                file_bytes = file_bytes[0:keep-1];
            end
            else if (flaw == FLAW_NONE && $urandom_range(0, 3) == 0)
                push_noise($urandom_range(1, 3));
        end
        foreach (file_bytes[k])
            byte_plan.push_back('{file_bytes[k], k == file_bytes.size() - 1});
    endtask

    task automatic send_byte(input wav_byte_t item, output logic produced, output res_t res);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            bs.valid <= 1'b0;
            @(posedge clk);
        end
        bs.valid <= 1'b1;
        bs.in_byte <= item.value;
        bs.end_of_stream <= item.last;
        @(posedge clk);
        while (!bs.ready)
            @(posedge clk);
        predict_byte(item.value, item.last, produced, res);
    endtask

    task automatic note_mismatch(input string what, input res_t want, input res_t got);
        if (mismatch_count < 10)
        begin
            $display("%s: expected kind=%0d byte=%02h last=%0b ch=%0d rate=%0d bits=%0d st=%0d",
                     what, want.kind, want.pcm_byte, want.data_last, want.channels,
                     want.frame_rate, want.sample_size, want.status);
            $display("    got kind=%0d byte=%02h last=%0b ch=%0d rate=%0d bits=%0d st=%0d",
                     got.kind, got.pcm_byte, got.data_last, got.channels,
                     got.frame_rate, got.sample_size, got.status);
        end
        mismatch_count++;
    endtask

    task automatic check_result();
        res_t got;
        res_t want;
        got = {rs.kind, rs.pcm_byte, rs.data_last, rs.channels, rs.frame_rate,
               rs.sample_size, rs.status};
        if (expected_results.size() == 0)
        begin
            note_mismatch("unexpected result", NO_RESULT, got);
            return;
        end
        want = expected_results.pop_front();
        if (got.kind !== want.kind || got.pcm_byte !== want.pcm_byte ||
            got.data_last !== want.data_last || got.channels !== want.channels ||
            got.frame_rate !== want.frame_rate ||
            got.sample_size !== want.sample_size || got.status !== want.status)
            note_mismatch("result mismatch", want, got);
    endtask

    // Result side: take and check results, stall at random, hold off once for a long stretch
    initial
    begin
        int   hold_left;
        logic hold_served;
        hold_left = 0;
        hold_served = 1'b0;
        rs.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rs.valid && rs.ready)
                check_result();
            if (hold_left != 0)
            begin
                rs.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_wanted && !hold_served)
            begin
                hold_served = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                rs.ready <= 1'b0;
            end
            else
                rs.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial
    begin
        dir_row_t  row;
        wav_byte_t item;
        logic      produced;
        res_t      predicted;
        int        idle_mode;
        int        cur_mode;
        bs.valid <= 1'b0;
        bs.in_byte <= '0;
        bs.end_of_stream <= 1'b0;
        rst_n <= 1'b0;
        reset_parser();
        while (byte_plan.size() < RANDOM_BYTES)
            add_file();
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < 24; r++)
        begin
            row = DIRECTED_ROWS[r];
            item = '{row.value, row.last};
            send_byte(item, produced, predicted);
            if (row.pinned)
            begin
                if (row.has_result)
                    expected_results.push_back(row.want);
            end
            else if (produced)
                expected_results.push_back(predicted);
        end

        cur_mode = -1;
        for (int i = 0; i < byte_plan.size(); i++)
        begin
            idle_mode = (i / SEGMENT_LEN) % 4;
            // Pause the stream until every expected result is out, then switch idling
            if (idle_mode != cur_mode)
            begin
                bs.valid <= 1'b0;
                @(posedge clk);
                while (expected_results.size() != 0)
                    @(posedge clk);
                cur_mode = idle_mode;
                send_idle_pct = (idle_mode == 1) ? 87 : (idle_mode == 3) ? 15 : 0;
                stall_pct = (idle_mode == 2) ? 87 : (idle_mode == 3) ? 15 : 0;
            end
            if (i == 20)
                hold_wanted = 1'b1;
            send_byte(byte_plan[i], produced, predicted);
            if (produced)
                expected_results.push_back(predicted);
        end
        bs.valid <= 1'b0;

        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
